// ----- rtl/core/ihp_pkg.sv -----
// shared types and command codes for the indexed min-heap
package ihp_pkg;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  item_id;
    logic [31:0] item_key;
  } req_t;

  typedef struct packed {
    logic [9:0]  out_id;
    logic [31:0] out_key;
    logic        status;
    logic [10:0] occupancy;
  } rsp_t;

endpackage

// ----- rtl/core/ihp_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
module ihp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ihp_out_reg.sv -----
// output register holding one response beat
module ihp_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ihp_pkg::rsp_t din,
  input  logic          rsp_ready,
  output logic          rsp_valid,
  output ihp_pkg::rsp_t rsp,
  output logic          free
);

  assign free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= din;
    end
  end

endmodule

// ----- rtl/core/indexed_min_heap.sv -----
// indexed binary min-heap: sequencer over heap, slot and key memories
// one command at a time; push looks up the id's slot, then compares up the parent chain,
// pop reads the root, moves the last entry to the top and compares down the child levels;
// clear, empty pop and no-ops respond directly; responses wait for a free output register.
// after reset a clearing pass writes every slot memory entry; no command is accepted until
// it ends. presence is checked against the heap, so clear only resets the count.
module indexed_min_heap #(
  parameter int NUM_IDS  = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ihp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ihp_pkg::rsp_t rsp
);

  localparam int ID_W  = $clog2(NUM_IDS);
  localparam int CNT_W = $clog2(NUM_IDS + 1);
  localparam int CW1   = CNT_W + 1;

  typedef enum logic [14:0] {
    S_INIT   = 15'h0001,
    S_IDLE   = 15'h0002,
    S_PUSH1  = 15'h0004,
    S_PUSH2  = 15'h0008,
    S_UP_KEY = 15'h0010,
    S_UP_CMP = 15'h0020,
    S_POP1   = 15'h0040,
    S_POP2   = 15'h0080,
    S_POP3   = 15'h0100,
    S_POP4   = 15'h0200,
    S_DN_L   = 15'h0400,
    S_DN_R   = 15'h0800,
    S_DN_CMP = 15'h1000,
    S_FIN    = 15'h2000,
    S_RESP   = 15'h4000
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [ID_W-1:0]      init_cnt, init_cnt_next;
  logic [ID_W-1:0]      cur_id, cur_id_next;
  logic [KEY_BITS-1:0]  cur_key, cur_key_next;
  logic [ID_W-1:0]      pos, pos_next;
  logic [ID_W-1:0]      par, par_next;
  logic [ID_W-1:0]      ch, ch_next;
  logic [ID_W-1:0]      oth_id, oth_id_next;
  logic [KEY_BITS-1:0]  oth_key, oth_key_next;
  logic [ID_W-1:0]      r_id, r_id_next;
  logic                 has_r, has_r_next;
  logic [ID_W-1:0]      res_id, res_id_next;
  logic [KEY_BITS-1:0]  res_key, res_key_next;
  logic                 res_st, res_st_next;

  logic                 heap_we, slot_we, key_we;
  logic [ID_W-1:0]      heap_waddr, heap_wdata, heap_raddr, heap_rdata;
  logic [ID_W-1:0]      slot_waddr, slot_wdata, slot_raddr, slot_rdata;
  logic [ID_W-1:0]      key_waddr, key_raddr;
  logic [KEY_BITS-1:0]  key_wdata, key_rdata;

  logic                 load, free;
  ihp_pkg::rsp_t        rsp_d;

  logic                 present;
  logic [ID_W-1:0]      j_sel;
  logic                 take_r;
  logic [ID_W-1:0]      c_id, c_slot;
  logic [KEY_BITS-1:0]  c_key;
  logic [CW1-1:0]       nj;

  assign req_ready = (state == S_IDLE);

  ihp_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  ihp_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  ihp_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_IDS)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  ihp_out_reg u_out (
    .clk(clk), .rst(rst), .load(load), .din(rsp_d), .rsp_ready(rsp_ready),
    .rsp_valid(rsp_valid), .rsp(rsp), .free(free)
  );

  always_comb begin
    rsp_d.out_id    = 10'(res_id);
    rsp_d.out_key   = 32'(res_key);
    rsp_d.status    = res_st;
    rsp_d.occupancy = 11'(cnt);
  end

  // helper terms for the sift steps
  always_comb begin
    present = (CNT_W'(pos) < cnt) && (heap_rdata == cur_id);
    j_sel   = present ? pos : ID_W'(cnt);
    take_r  = has_r && (oth_key > key_rdata);
    c_id    = take_r ? r_id : oth_id;
    c_key   = take_r ? key_rdata : oth_key;
    c_slot  = take_r ? ID_W'(ch + 1'b1) : ch;
    nj      = (CW1'(c_slot) << 1) + CW1'(1);
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    init_cnt_next = init_cnt;
    cur_id_next   = cur_id;
    cur_key_next  = cur_key;
    pos_next      = pos;
    par_next      = par;
    ch_next       = ch;
    oth_id_next   = oth_id;
    oth_key_next  = oth_key;
    r_id_next     = r_id;
    has_r_next    = has_r;
    res_id_next   = res_id;
    res_key_next  = res_key;
    res_st_next   = res_st;
    load          = 1'b0;
    heap_we       = 1'b0;
    heap_waddr    = pos;
    heap_wdata    = cur_id;
    heap_raddr    = '0;
    slot_we       = 1'b0;
    slot_waddr    = cur_id;
    slot_wdata    = pos;
    slot_raddr    = '0;
    key_we        = 1'b0;
    key_waddr     = ID_W'(req.item_id);
    key_wdata     = KEY_BITS'(req.item_key);
    key_raddr     = '0;

    unique case (state)
      S_INIT: begin
        slot_we       = 1'b1;
        slot_waddr    = init_cnt;
        slot_wdata    = '0;
        init_cnt_next = init_cnt + 1'b1;
        if (32'(init_cnt) == NUM_IDS - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          res_id_next  = '0;
          res_key_next = '0;
          res_st_next  = 1'b0;
          state_next   = S_RESP;
          priority if (req.cmd == ihp_pkg::CMD_PUSH) begin
            if (32'(req.item_id) < NUM_IDS) begin
              key_we       = 1'b1;
              slot_raddr   = ID_W'(req.item_id);
              cur_id_next  = ID_W'(req.item_id);
              cur_key_next = KEY_BITS'(req.item_key);
              state_next   = S_PUSH1;
            end
          end else if (req.cmd == ihp_pkg::CMD_POP) begin
            if (cnt == '0) begin
              res_st_next = 1'b1;
            end else begin
              heap_raddr = '0;
              state_next = S_POP1;
            end
          end else if (req.cmd == ihp_pkg::CMD_CLEAR) begin
            cnt_next = '0;
          end else begin
            // unused command, nothing to do
          end
        end
      end
      S_PUSH1: begin
        pos_next   = slot_rdata;
        heap_raddr = slot_rdata;
        state_next = S_PUSH2;
      end
      S_PUSH2: begin
        pos_next = j_sel;
        if (!present) begin
          cnt_next = cnt + 1'b1;
        end
        if (j_sel == '0) begin
          state_next = S_FIN;
        end else begin
          par_next   = (j_sel - 1'b1) >> 1;
          heap_raddr = (j_sel - 1'b1) >> 1;
          state_next = S_UP_KEY;
        end
      end
      S_UP_KEY: begin
        oth_id_next = heap_rdata;
        key_raddr   = heap_rdata;
        state_next  = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (key_rdata > cur_key) begin
          heap_we    = 1'b1;
          heap_wdata = oth_id;
          slot_we    = 1'b1;
          slot_waddr = oth_id;
          pos_next   = par;
          if (par == '0) begin
            state_next = S_FIN;
          end else begin
            par_next   = (par - 1'b1) >> 1;
            heap_raddr = (par - 1'b1) >> 1;
            state_next = S_UP_KEY;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_POP1: begin
        oth_id_next = heap_rdata;
        key_raddr   = heap_rdata;
        state_next  = S_POP2;
      end
      S_POP2: begin
        res_id_next  = oth_id;
        res_key_next = key_rdata;
        cnt_next     = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = S_RESP;
        end else begin
          heap_raddr = ID_W'(cnt - 1'b1);
          state_next = S_POP3;
        end
      end
      S_POP3: begin
        cur_id_next = heap_rdata;
        key_raddr   = heap_rdata;
        state_next  = S_POP4;
      end
      S_POP4: begin
        cur_key_next = key_rdata;
        pos_next     = '0;
        if (cnt > CNT_W'(1)) begin
          ch_next    = ID_W'(1);
          heap_raddr = ID_W'(1);
          state_next = S_DN_L;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DN_L: begin
        oth_id_next = heap_rdata;
        key_raddr   = heap_rdata;
        has_r_next  = (CW1'(ch) + CW1'(1)) < CW1'(cnt);
        heap_raddr  = ID_W'(ch + 1'b1);
        state_next  = S_DN_R;
      end
      S_DN_R: begin
        oth_key_next = key_rdata;
        r_id_next    = heap_rdata;
        key_raddr    = heap_rdata;
        state_next   = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (cur_key <= c_key) begin
          state_next = S_FIN;
        end else begin
          heap_we    = 1'b1;
          heap_wdata = c_id;
          slot_we    = 1'b1;
          slot_waddr = c_id;
          pos_next   = c_slot;
          if (nj < CW1'(cnt)) begin
            ch_next    = ID_W'(nj);
            heap_raddr = ID_W'(nj);
            state_next = S_DN_L;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        heap_we    = 1'b1;
        slot_we    = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      cnt      <= '0;
      init_cnt <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      init_cnt <= init_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_id  <= cur_id_next;
    cur_key <= cur_key_next;
    pos     <= pos_next;
    par     <= par_next;
    ch      <= ch_next;
    oth_id  <= oth_id_next;
    oth_key <= oth_key_next;
    r_id    <= r_id_next;
    has_r   <= has_r_next;
    res_id  <= res_id_next;
    res_key <= res_key_next;
    res_st  <= res_st_next;
  end

endmodule

// ----- rtl/core/ihp_chk.sv -----
// port-level checker for the indexed min-heap and its bind
module ihp_chk #(
  parameter int NUM_IDS = 1024
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ihp_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ihp_pkg::rsp_t rsp
);

  // stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one command in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.occupancy) <= NUM_IDS)
    else $error("occupancy beyond capacity");

  // empty pop leaves an empty heap and zero payload
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |->
      rsp.out_id == '0 && rsp.out_key == '0 && rsp.occupancy == '0)
    else $error("bad empty-pop response");

endmodule

bind indexed_min_heap ihp_chk #(.NUM_IDS(NUM_IDS)) u_ihp_chk (.*);
